FILE: hw/rtl/spi_nor_flash_command_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer assertion macros
// Concurrent assertion wrappers that vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SNFCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SNFCS_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SNFCS_ASSERT(lbl, clk, rstn, prop, msg)
`define SNFCS_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared types, codes and helpers of the command sequencer.
// ----------------------------------------------------------------------------
package snfcs_pkg;

  localparam longint unsigned DieBytesDefault = 64'd67108864;
  localparam int unsigned MaxWriteBytesDefault = 512;
  localparam int unsigned UnitsDefault = 2;

  localparam logic [2:0] OpRead = 3'd0;
  localparam logic [2:0] OpProgram = 3'd1;
  localparam logic [2:0] OpErase = 3'd2;
  localparam logic [2:0] OpDone = 3'd3;
  localparam logic [2:0] OpTick = 3'd4;

  localparam logic [7:0] CmdRdsr = 8'h05;
  localparam logic [7:0] CmdWren = 8'h06;
  localparam logic [7:0] CmdPp4 = 8'h12;
  localparam logic [7:0] CmdRead4 = 8'h13;
  localparam logic [7:0] CmdSe4 = 8'hDC;
  localparam logic [7:0] CmdClsr = 8'h30;
  localparam logic [7:0] StWip = 8'h01;
  localparam logic [7:0] StErr = 8'h60;

  localparam logic [3:0] RcOk = 4'd0;
  localparam logic [3:0] RcBadUnit = 4'd1;
  localparam logic [3:0] RcBusy = 4'd2;
  localparam logic [3:0] RcReadLong = 4'd3;
  localparam logic [3:0] RcWriteLong = 4'd4;
  localparam logic [3:0] RcBadAddr = 4'd5;
  localparam logic [3:0] RcTimeout = 4'd6;
  localparam logic [3:0] RcWip = 4'd7;
  localparam logic [3:0] RcPeErr = 4'd8;
  localparam logic [3:0] RcTooLong = 4'd9;

  localparam logic [2:0] CfgReadTmo = 3'd0;
  localparam logic [2:0] CfgCmdTmo = 3'd1;
  localparam logic [2:0] CfgPgmDelay = 3'd2;
  localparam logic [2:0] CfgErsDelay = 3'd3;
  localparam logic [2:0] CfgTries = 3'd4;

  localparam logic [39:0] Tmo40Max = 40'hFF_FFFF_FFFF;

  typedef enum logic [11:0] {
    PhIdle   = 12'b0000_0000_0001,
    PhRdPoll = 12'b0000_0000_0010,
    PhRdRun  = 12'b0000_0000_0100,
    PhPgPoll = 12'b0000_0000_1000,
    PhPgWren = 12'b0000_0001_0000,
    PhXfer   = 12'b0000_0010_0000,
    PhWip    = 12'b0000_0100_0000,
    PhDelay  = 12'b0000_1000_0000,
    PhClear  = 12'b0001_0000_0000,
    PhErPoll = 12'b0010_0000_0000,
    PhErWren = 12'b0100_0000_0000,
    PhError  = 12'b1000_0000_0000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        busy;
    logic [7:0]  status;
    logic [31:0] laddr;
    logic [26:0] jlen;
    logic        die;
    logic        erase;
    logic [39:0] tmo;
    logic [19:0] dly;
    logic [7:0]  tries;
  } unit_t;

  typedef struct packed {
    logic [1:0]  unit;
    logic        kind;
    logic [7:0]  opcode;
    logic        die;
    logic [31:0] info;
    logic [26:0] dlen;
    logic [3:0]  code;
    logic        last;
  } res_t;

  function automatic logic [3:0] phase_num(phase_e ph);
    logic [3:0] n;
    case (ph)
      PhIdle:   n = 4'd1;
      PhRdPoll: n = 4'd2;
      PhRdRun:  n = 4'd3;
      PhPgPoll: n = 4'd4;
      PhPgWren: n = 4'd5;
      PhXfer:   n = 4'd6;
      PhWip:    n = 4'd7;
      PhDelay:  n = 4'd8;
      PhClear:  n = 4'd9;
      PhErPoll: n = 4'd10;
      PhErWren: n = 4'd11;
      PhError:  n = 4'd12;
      default:  n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic res_t mk_res(logic [1:0] unit, logic kind, logic [7:0] opc, logic die,
                                  logic [31:0] info, logic [26:0] dlen, logic [3:0] code);
    res_t r;
    r.unit = unit;
    r.kind = kind;
    r.opcode = opc;
    r.die = die;
    r.info = info;
    r.dlen = dlen;
    r.code = code;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [39:0] sat40(logic [43:0] p);
    return (p > 44'(Tmo40Max)) ? Tmo40Max : p[39:0];
  endfunction

endpackage

FILE: hw/rtl/spi_nor_flash_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Checks flash requests and steps two units through their SPI command flows.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tuser op, tdata unit/address/length/status
// m_axis    out  tvalid/tready      tuser kind, tdata fields, tlast last
// cfg       in   cfg_we_i           cfg_idx_i register index, cfg_data_i value
//
// Each request is evaluated in the cycle it is accepted and yields up to four
// results, which enter an eight-entry result queue and leave one per cycle while m_axis_tready is high.
// The input is ready while the queue has room for four results, so requests
// flow at one per cycle as long as the output keeps up.
// Reset puts both units in idle and loads the register defaults.
`include "spi_nor_flash_command_sequencer_unit_macros.svh"

module spi_nor_flash_command_sequencer_unit #(
  parameter longint unsigned DIE_BYTES = snfcs_pkg::DieBytesDefault,
  parameter int unsigned MAX_WRITE_BYTES = snfcs_pkg::MaxWriteBytesDefault,
  parameter int unsigned UNITS = snfcs_pkg::UnitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // unit, address, length, status_byte, zero fill
  input  logic [2:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // out_unit, opcode, die, info, data_length,
                                     // result_code, zero fill
  output logic [0:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);

  localparam logic [32:0] DieB = 33'(DIE_BYTES);
  localparam logic [32:0] TwoDieB = 33'(2 * DIE_BYTES);
  localparam logic [26:0] MaxWr = 27'(MAX_WRITE_BYTES);

  logic [15:0] rtpb_q, ctmo_q;
  logic [19:0] pdly_q, edly_q;
  logic [7:0]  tries_q;

  snfcs_pkg::unit_t ust_q [2];
  snfcs_pkg::unit_t ust_d [2];

  snfcs_pkg::res_t fifo_q [8];
  logic [2:0] wr_q, rd_q;
  logic [3:0] cnt_q;

  snfcs_pkg::res_t rs [4];
  logic [3:0] rv;

  logic [2:0]  in_op;
  logic [1:0]  in_unit;
  logic [31:0] in_addr;
  logic [26:0] in_len;
  logic [7:0]  in_st;
  logic        acc, pop, uvalid;
  logic [26:0] rlen;
  logic [43:0] prd [2];
  logic [43:0] ppg [2];
  logic [39:0] ct100;

  assign in_unit = s_axis_tdata[1:0];
  assign in_addr = s_axis_tdata[33:2];
  assign in_len  = s_axis_tdata[60:34];
  assign in_st   = s_axis_tdata[68:61];
  assign in_op   = s_axis_tuser;

  assign s_axis_tready = (cnt_q <= 4'd4);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 4'd0);
  assign pop = m_axis_tvalid && m_axis_tready;
  assign uvalid = (in_unit >= 2'd1) && (32'(in_unit) <= UNITS);
  assign rlen = (in_op == snfcs_pkg::OpErase) ? 27'd0 : in_len;
  assign ct100 = 40'(ctmo_q) * 40'd100;

  always_comb begin
    for (int u = 0; u < 2; u++) begin
      prd[u] = 44'(ust_q[u].jlen) * 44'(rtpb_q);
      ppg[u] = 44'(ctmo_q) * (44'(ust_q[u].jlen) + 44'd5);
    end
  end

  always_comb begin
    logic [1:0] un;
    for (int u = 0; u < 2; u++) ust_d[u] = ust_q[u];
    for (int j = 0; j < 4; j++) begin
      rs[j] = '0;
      rv[j] = 1'b0;
    end
    if (acc) begin
      if (in_op <= snfcs_pkg::OpErase) begin
        if (!uvalid) begin
          rv[0] = 1'b1;
          rs[0] = snfcs_pkg::mk_res(in_unit, 1'b1, 8'd0, 1'b0, in_addr, rlen,
                                    snfcs_pkg::RcBadUnit);
        end else begin
          for (int u = 0; u < 2; u++) begin
            if (in_unit == 2'(u + 1)) begin
              rv[2*u] = 1'b1;
              if (ust_q[u].phase != snfcs_pkg::PhIdle) begin
                rs[2*u] = snfcs_pkg::mk_res(in_unit, 1'b1, 8'd0, 1'b0,
                  32'(snfcs_pkg::phase_num(ust_q[u].phase)), rlen, snfcs_pkg::RcBusy);
              end else if (in_op == snfcs_pkg::OpRead && {6'd0, in_len} > DieB) begin
                rs[2*u] = snfcs_pkg::mk_res(in_unit, 1'b1, 8'd0, 1'b0, in_addr, rlen,
                                            snfcs_pkg::RcReadLong);
              end else if (in_op == snfcs_pkg::OpProgram && in_len > MaxWr) begin
                rs[2*u] = snfcs_pkg::mk_res(in_unit, 1'b1, 8'd0, 1'b0, in_addr, rlen,
                                            snfcs_pkg::RcWriteLong);
              end else if ({1'b0, in_addr} >= TwoDieB) begin
                rs[2*u] = snfcs_pkg::mk_res(in_unit, 1'b1, 8'd0, 1'b0, in_addr, rlen,
                                            snfcs_pkg::RcBadAddr);
              end else begin
                if ({1'b0, in_addr} < DieB) begin
                  ust_d[u].die = 1'b0;
                  ust_d[u].laddr = in_addr;
                end else begin
                  ust_d[u].die = 1'b1;
                  ust_d[u].laddr = 32'({1'b0, in_addr} - DieB);
                end
                ust_d[u].jlen = rlen;
                ust_d[u].erase = (in_op == snfcs_pkg::OpErase);
                ust_d[u].status = 8'd0;
                ust_d[u].busy = 1'b1;
                ust_d[u].tmo = 40'(ctmo_q);
                ust_d[u].phase = (in_op == snfcs_pkg::OpRead) ? snfcs_pkg::PhRdPoll :
                                 (in_op == snfcs_pkg::OpProgram) ? snfcs_pkg::PhPgPoll :
                                 snfcs_pkg::PhErPoll;
                rs[2*u] = snfcs_pkg::mk_res(in_unit, 1'b0, snfcs_pkg::CmdRdsr,
                  ust_d[u].die, 32'd0, 27'd1, snfcs_pkg::RcOk);
              end
            end
          end
        end
      end else if (in_op == snfcs_pkg::OpDone) begin
        for (int u = 0; u < 2; u++) begin
          if (uvalid && in_unit == 2'(u + 1) && ust_q[u].busy) begin
            ust_d[u].busy = 1'b0;
            if (ust_q[u].phase == snfcs_pkg::PhRdPoll ||
                ust_q[u].phase == snfcs_pkg::PhPgPoll ||
                ust_q[u].phase == snfcs_pkg::PhWip ||
                ust_q[u].phase == snfcs_pkg::PhErPoll) begin
              ust_d[u].status = in_st;
            end
          end
        end
      end else if (in_op == snfcs_pkg::OpTick) begin
        for (int u = 0; u < 2; u++) begin
          un = 2'(u + 1);
          if (32'(u) < UNITS) begin
            if (ust_q[u].busy) begin
              if (ust_q[u].tmo != 40'd0) begin
                ust_d[u].tmo = ust_q[u].tmo - 40'd1;
                if (ust_q[u].tmo == 40'd1) begin
                  ust_d[u].busy = 1'b0;
                  ust_d[u].phase = snfcs_pkg::PhError;
                  rv[2*u] = 1'b1;
                  rs[2*u] = snfcs_pkg::mk_res(un, 1'b1, 8'd0, ust_q[u].die,
                    32'(snfcs_pkg::phase_num(ust_q[u].phase)), 27'd0,
                    snfcs_pkg::RcTimeout);
                end
              end
            end else begin
              ust_d[u].tmo = 40'd0;
              case (ust_q[u].phase)
                snfcs_pkg::PhRdPoll, snfcs_pkg::PhPgPoll, snfcs_pkg::PhErPoll: begin
                  rv[2*u] = 1'b1;
                  if ((ust_q[u].status & snfcs_pkg::StWip) != 8'd0) begin
                    ust_d[u].phase = snfcs_pkg::PhError;
                    rs[2*u] = snfcs_pkg::mk_res(un, 1'b1, 8'd0, ust_q[u].die,
                      ust_q[u].laddr, ust_q[u].jlen, snfcs_pkg::RcWip);
                  end else if (ust_q[u].phase == snfcs_pkg::PhRdPoll) begin
                    ust_d[u].busy = 1'b1;
                    ust_d[u].tmo = snfcs_pkg::sat40(prd[u]);
                    ust_d[u].phase = snfcs_pkg::PhRdRun;
                    rs[2*u] = snfcs_pkg::mk_res(un, 1'b0, snfcs_pkg::CmdRead4,
                      ust_q[u].die, ust_q[u].laddr, ust_q[u].jlen, snfcs_pkg::RcOk);
                  end else begin
                    ust_d[u].busy = 1'b1;
                    ust_d[u].tmo = 40'(ctmo_q);
                    ust_d[u].phase = (ust_q[u].phase == snfcs_pkg::PhPgPoll) ?
                                     snfcs_pkg::PhPgWren : snfcs_pkg::PhErWren;
                    rs[2*u] = snfcs_pkg::mk_res(un, 1'b0, snfcs_pkg::CmdWren,
                      ust_q[u].die, 32'd0, 27'd0, snfcs_pkg::RcOk);
                  end
                end
                snfcs_pkg::PhRdRun: begin
                  rv[2*u] = 1'b1;
                  ust_d[u].phase = snfcs_pkg::PhIdle;
                  rs[2*u] = snfcs_pkg::mk_res(un, 1'b1, 8'd0, ust_q[u].die,
                    ust_q[u].laddr, ust_q[u].jlen, snfcs_pkg::RcOk);
                end
                snfcs_pkg::PhPgWren: begin
                  rv[2*u] = 1'b1;
                  ust_d[u].busy = 1'b1;
                  ust_d[u].tmo = snfcs_pkg::sat40(ppg[u]);
                  ust_d[u].phase = snfcs_pkg::PhXfer;
                  rs[2*u] = snfcs_pkg::mk_res(un, 1'b0, snfcs_pkg::CmdPp4, ust_q[u].die,
                    ust_q[u].laddr, ust_q[u].jlen, snfcs_pkg::RcOk);
                end
                snfcs_pkg::PhErWren: begin
                  rv[2*u] = 1'b1;
                  ust_d[u].busy = 1'b1;
                  ust_d[u].tmo = 40'(ctmo_q);
                  ust_d[u].phase = snfcs_pkg::PhXfer;
                  rs[2*u] = snfcs_pkg::mk_res(un, 1'b0, snfcs_pkg::CmdSe4, ust_q[u].die,
                    ust_q[u].laddr, 27'd0, snfcs_pkg::RcOk);
                end
                snfcs_pkg::PhXfer: begin
                  rv[2*u] = 1'b1;
                  ust_d[u].tries = tries_q;
                  ust_d[u].busy = 1'b1;
                  ust_d[u].tmo = ct100;
                  ust_d[u].phase = snfcs_pkg::PhWip;
                  rs[2*u] = snfcs_pkg::mk_res(un, 1'b0, snfcs_pkg::CmdRdsr, ust_q[u].die,
                    32'd0, 27'd1, snfcs_pkg::RcOk);
                end
                snfcs_pkg::PhWip: begin
                  if ((ust_q[u].status & snfcs_pkg::StWip) != 8'd0) begin
                    ust_d[u].dly = ust_q[u].erase ? edly_q : pdly_q;
                    ust_d[u].phase = snfcs_pkg::PhDelay;
                  end else if ((ust_q[u].status & snfcs_pkg::StErr) != 8'd0) begin
                    rv[2*u] = 1'b1;
                    rv[2*u+1] = 1'b1;
                    ust_d[u].busy = 1'b1;
                    ust_d[u].tmo = 40'(ctmo_q);
                    ust_d[u].phase = snfcs_pkg::PhClear;
                    rs[2*u] = snfcs_pkg::mk_res(un, 1'b0, snfcs_pkg::CmdClsr, ust_q[u].die,
                      32'd0, 27'd0, snfcs_pkg::RcOk);
                    rs[2*u+1] = snfcs_pkg::mk_res(un, 1'b1, 8'd0, ust_q[u].die,
                      ust_q[u].laddr, ust_q[u].jlen, snfcs_pkg::RcPeErr);
                  end else begin
                    rv[2*u] = 1'b1;
                    ust_d[u].phase = snfcs_pkg::PhIdle;
                    rs[2*u] = snfcs_pkg::mk_res(un, 1'b1, 8'd0, ust_q[u].die,
                      ust_q[u].laddr, ust_q[u].jlen, snfcs_pkg::RcOk);
                  end
                end
                snfcs_pkg::PhDelay: begin
                  if (ust_q[u].dly > 20'd1) begin
                    ust_d[u].dly = ust_q[u].dly - 20'd1;
                  end else begin
                    ust_d[u].dly = 20'd0;
                    rv[2*u] = 1'b1;
                    if (ust_q[u].tries <= 8'd1) begin
                      ust_d[u].tries = 8'd0;
                      ust_d[u].phase = snfcs_pkg::PhError;
                      rs[2*u] = snfcs_pkg::mk_res(un, 1'b1, 8'd0, ust_q[u].die,
                        ust_q[u].laddr, ust_q[u].jlen, snfcs_pkg::RcTooLong);
                    end else begin
                      ust_d[u].tries = ust_q[u].tries - 8'd1;
                      ust_d[u].busy = 1'b1;
                      ust_d[u].tmo = 40'(ctmo_q);
                      ust_d[u].phase = snfcs_pkg::PhWip;
                      rs[2*u] = snfcs_pkg::mk_res(un, 1'b0, snfcs_pkg::CmdRdsr,
                        ust_q[u].die, 32'd0, 27'd1, snfcs_pkg::RcOk);
                    end
                  end
                end
                snfcs_pkg::PhClear: begin
                  ust_d[u].phase = snfcs_pkg::PhIdle;
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
    end
    rs[3].last = rv[3];
    rs[2].last = rv[2] && !rv[3];
    rs[1].last = rv[1] && !rv[2] && !rv[3];
    rs[0].last = rv[0] && !rv[1] && !rv[2] && !rv[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtpb_q <= 16'd1000;
      ctmo_q <= 16'd1000;
      pdly_q <= 20'd1;
      edly_q <= 20'd20000;
      tries_q <= 8'd25;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        snfcs_pkg::CfgReadTmo:  rtpb_q <= cfg_data_i[15:0];
        snfcs_pkg::CfgCmdTmo:   ctmo_q <= cfg_data_i[15:0];
        snfcs_pkg::CfgPgmDelay: pdly_q <= cfg_data_i;
        snfcs_pkg::CfgErsDelay: edly_q <= cfg_data_i;
        snfcs_pkg::CfgTries:    tries_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < 2; u++) begin
        ust_q[u] <= snfcs_pkg::unit_t'{phase: snfcs_pkg::PhIdle, default: '0};
      end
    end else begin
      for (int u = 0; u < 2; u++) ust_q[u] <= ust_d[u];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [2:0] np;
    if (!rst_ni) begin
      wr_q <= 3'd0;
      rd_q <= 3'd0;
      cnt_q <= 4'd0;
    end else begin
      np = 3'd0;
      for (int j = 0; j < 4; j++) begin
        if (rv[j]) begin
          np = np + 3'd1;
        end
      end
      wr_q <= wr_q + np;
      if (pop) rd_q <= rd_q + 3'd1;
      cnt_q <= cnt_q + 4'(np) - 4'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [2:0] k;
    k = 3'd0;
    for (int j = 0; j < 4; j++) begin
      if (rv[j]) begin
        fifo_q[wr_q + k] <= rs[j];
        k = k + 3'd1;
      end
    end
  end

  assign m_axis_tdata = {6'd0, fifo_q[rd_q].code, fifo_q[rd_q].dlen, fifo_q[rd_q].info,
                         fifo_q[rd_q].die, fifo_q[rd_q].opcode, fifo_q[rd_q].unit};
  assign m_axis_tuser = fifo_q[rd_q].kind;
  assign m_axis_tlast = fifo_q[rd_q].last;

  `SNFCS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= 4'd8, "result queue overflow")
  `SNFCS_ASSERT(a_room, clk_i, rst_ni, s_axis_tready |-> (cnt_q <= 4'd4), "no room for results")
  `SNFCS_ASSERT(a_err0, clk_i, rst_ni,
    (ust_q[0].phase == snfcs_pkg::PhError) |=> (ust_q[0].phase == snfcs_pkg::PhError),
    "unit 1 left error state")
  `SNFCS_ASSERT(a_err1, clk_i, rst_ni,
    (ust_q[1].phase == snfcs_pkg::PhError) |=> (ust_q[1].phase == snfcs_pkg::PhError),
    "unit 2 left error state")

endmodule

FILE: dv/spi_nor_flash_command_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Runs a directed table of requests, then random request, transfer-done and
// tick traffic under several register settings. An in-bench predictor of
// both flash units supplies the expected command and completion stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_unit_tb;

  localparam logic [3:0] P_IDLE = 4'd1;
  localparam logic [3:0] P_RD_POLL = 4'd2;
  localparam logic [3:0] P_RD_RUN = 4'd3;
  localparam logic [3:0] P_PG_POLL = 4'd4;
  localparam logic [3:0] P_PG_WREN = 4'd5;
  localparam logic [3:0] P_XFER = 4'd6;
  localparam logic [3:0] P_WIP = 4'd7;
  localparam logic [3:0] P_DELAY = 4'd8;
  localparam logic [3:0] P_CLEAR = 4'd9;
  localparam logic [3:0] P_ER_POLL = 4'd10;
  localparam logic [3:0] P_ER_WREN = 4'd11;
  localparam logic [3:0] P_ERROR = 4'd12;
  localparam longint unsigned DIE = 64'd67108864;

  typedef struct {
    logic [3:0]  ph;
    bit          busy;
    logic [7:0]  status;
    logic [31:0] laddr;
    logic [26:0] jlen;
    bit          die;
    bit          erase;
    logic [39:0] tmo;
    logic [19:0] dly;
    logic [7:0]  tries;
  } flash_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  un;
    logic [31:0] ad;
    logic [26:0] ln;
    logic [7:0]  sb;
    logic        chk;
    logic [3:0]  code;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;

  flash_t            flash [0:3];
  logic [15:0]       rto_r, cto_r;
  logic [19:0]       pdly_r, edly_r;
  logic [7:0]        tries_r;
  snfcs_pkg::res_t   expected_q[$];
  snfcs_pkg::res_t   step_q[$];
  int                fails = 0;
  int                tx_idle = 0;
  int                rx_idle = 0;
  int                hold_cycles = 0;

  spi_nor_flash_command_sequencer_unit uut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [39:0] clip40(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return (p > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : p[39:0];
  endfunction

  function automatic void emit(int u, logic kind, logic [7:0] opc, logic die,
                               logic [31:0] info, logic [26:0] dlen, logic [3:0] code);
    snfcs_pkg::res_t r;
    r = '{unit: u[1:0], kind: kind, opcode: opc, die: die, info: info, dlen: dlen,
          code: code, last: 1'b0};
    step_q.push_back(r);
  endfunction

  function automatic void issue(int u, logic [7:0] opc, logic [31:0] info,
                                logic [26:0] dlen, logic [39:0] tmo, logic [3:0] nxt);
    emit(u, 1'b0, opc, flash[u].die, info, dlen, snfcs_pkg::RcOk);
    flash[u].busy = 1'b1;
    flash[u].tmo = tmo;
    flash[u].ph = nxt;
  endfunction

  function automatic void complete(int u, logic [3:0] code, logic [3:0] nxt);
    emit(u, 1'b1, 8'h00, flash[u].die, flash[u].laddr, flash[u].jlen, code);
    flash[u].ph = nxt;
  endfunction

  function automatic void tick_flash(int u);
    logic [39:0] ct;
    ct = 40'(cto_r);
    if (flash[u].busy) begin
      if (flash[u].tmo > 0) begin
        flash[u].tmo--;
        if (flash[u].tmo == 0) begin
          flash[u].busy = 1'b0;
          emit(u, 1'b1, 8'h00, flash[u].die, 32'(flash[u].ph), '0, snfcs_pkg::RcTimeout);
          flash[u].ph = P_ERROR;
        end
      end
      return;
    end
    flash[u].tmo = '0;
    case (flash[u].ph)
      P_RD_POLL: begin
        if ((flash[u].status & snfcs_pkg::StWip) != 0)
          complete(u, snfcs_pkg::RcWip, P_ERROR);
        else issue(u, snfcs_pkg::CmdRead4, flash[u].laddr, flash[u].jlen,
                   clip40(64'(flash[u].jlen), 64'(rto_r)), P_RD_RUN);
      end
      P_RD_RUN: complete(u, snfcs_pkg::RcOk, P_IDLE);
      P_PG_POLL, P_ER_POLL: begin
        if ((flash[u].status & snfcs_pkg::StWip) != 0)
          complete(u, snfcs_pkg::RcWip, P_ERROR);
        else issue(u, snfcs_pkg::CmdWren, '0, '0, ct,
                   (flash[u].ph == P_PG_POLL) ? P_PG_WREN : P_ER_WREN);
      end
      P_PG_WREN: issue(u, snfcs_pkg::CmdPp4, flash[u].laddr, flash[u].jlen,
                       clip40(64'(ct), 64'd5 + 64'(flash[u].jlen)), P_XFER);
      P_ER_WREN: issue(u, snfcs_pkg::CmdSe4, flash[u].laddr, '0, ct, P_XFER);
      P_XFER: begin
        flash[u].tries = tries_r;
        issue(u, snfcs_pkg::CmdRdsr, '0, 27'd1, ct * 40'd100, P_WIP);
      end
      P_WIP: begin
        if ((flash[u].status & snfcs_pkg::StWip) != 0) begin
          flash[u].dly = flash[u].erase ? edly_r : pdly_r;
          flash[u].ph = P_DELAY;
        end else if ((flash[u].status & snfcs_pkg::StErr) != 0) begin
          issue(u, snfcs_pkg::CmdClsr, '0, '0, ct, P_CLEAR);
          complete(u, snfcs_pkg::RcPeErr, P_CLEAR);
        end else begin
          complete(u, snfcs_pkg::RcOk, P_IDLE);
        end
      end
      P_DELAY: begin
        if (flash[u].dly > 1) begin
          flash[u].dly--;
        end else begin
          flash[u].dly = '0;
          if (flash[u].tries <= 1) begin
            flash[u].tries = '0;
            complete(u, snfcs_pkg::RcTooLong, P_ERROR);
          end else begin
            flash[u].tries--;
            issue(u, snfcs_pkg::CmdRdsr, '0, 27'd1, ct, P_WIP);
          end
        end
      end
      P_CLEAR: flash[u].ph = P_IDLE;
      default: ;
    endcase
  endfunction

  function automatic void predict_step(logic [2:0] op, logic [1:0] un, logic [31:0] ad,
                                       logic [26:0] ln, logic [7:0] sb);
    bit          ok_unit;
    logic [26:0] rlen;
    ok_unit = (un == 2'd1) || (un == 2'd2);
    rlen = (op == snfcs_pkg::OpErase) ? '0 : ln;
    step_q.delete();
    if (op == snfcs_pkg::OpRead || op == snfcs_pkg::OpProgram || op == snfcs_pkg::OpErase) begin
      if (!ok_unit) emit(un, 1'b1, 8'h00, 1'b0, ad, rlen, snfcs_pkg::RcBadUnit);
      else if (flash[un].ph != P_IDLE)
        emit(un, 1'b1, 8'h00, 1'b0, 32'(flash[un].ph), rlen, snfcs_pkg::RcBusy);
      else if (op == snfcs_pkg::OpRead && ln > DIE)
        emit(un, 1'b1, 8'h00, 1'b0, ad, rlen, snfcs_pkg::RcReadLong);
      else if (op == snfcs_pkg::OpProgram && ln > snfcs_pkg::MaxWriteBytesDefault)
        emit(un, 1'b1, 8'h00, 1'b0, ad, rlen, snfcs_pkg::RcWriteLong);
      else if (ad >= 2 * DIE) emit(un, 1'b1, 8'h00, 1'b0, ad, rlen, snfcs_pkg::RcBadAddr);
      else begin
        flash[un].die = (ad >= DIE);
        flash[un].laddr = (ad >= DIE) ? ad - 32'(DIE) : ad;
        flash[un].jlen = rlen;
        flash[un].erase = (op == snfcs_pkg::OpErase);
        flash[un].status = '0;
        issue(un, snfcs_pkg::CmdRdsr, '0, 27'd1, 40'(cto_r),
              (op == snfcs_pkg::OpRead) ? P_RD_POLL :
              (op == snfcs_pkg::OpProgram) ? P_PG_POLL : P_ER_POLL);
      end
    end else if (op == snfcs_pkg::OpDone) begin
      if (ok_unit && flash[un].busy) begin
        flash[un].busy = 1'b0;
        if (flash[un].ph inside {P_RD_POLL, P_PG_POLL, P_WIP, P_ER_POLL})
          flash[un].status = sb;
      end
    end else if (op == snfcs_pkg::OpTick) begin
      tick_flash(1);
      tick_flash(2);
    end
    if (step_q.size() > 0) step_q[$].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  task automatic send_request(logic [2:0] op, logic [1:0] un, logic [31:0] ad,
                              logic [26:0] ln, logic [7:0] sb);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, sb, ln, ad, un};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_step(op, un, ad, ln, sb);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] rto, logic [15:0] cto, logic [19:0] pdly,
                          logic [19:0] edly, logic [7:0] tries);
    logic [19:0] vals [5];
    logic [2:0]  idx [5];
    vals = '{20'(rto), 20'(cto), pdly, edly, 20'(tries)};
    idx = '{snfcs_pkg::CfgReadTmo, snfcs_pkg::CfgCmdTmo, snfcs_pkg::CfgPgmDelay,
            snfcs_pkg::CfgErsDelay, snfcs_pkg::CfgTries};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    rto_r = rto;
    cto_r = cto;
    pdly_r = pdly;
    edly_r = edly;
    tries_r = tries;
  endtask

  task automatic random_request(bit allow_err);
    int          r;
    logic [2:0]  op;
    logic [1:0]  un;
    logic [31:0] ad;
    logic [26:0] ln;
    logic [7:0]  sb;
    logic [19:0] wdly;
    r = $urandom_range(0, 99);
    un = 2'($urandom_range(1, 2));
    ad = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 134217727));
    ln = 27'($urandom_range(0, 600));
    sb = 8'($urandom);
    if (r < 6) begin
      op = 3'($urandom_range(5, 7));
    end else if (r < 32) begin
      op = 3'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) un = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'd3;
      if ($urandom_range(0, 7) == 0) ln = 27'($urandom);
      else if (op == snfcs_pkg::OpProgram) ln = 27'($urandom_range(0, 512));
    end else if (r < (allow_err ? 50 : 62)) begin
      op = snfcs_pkg::OpDone;
      if (!flash[un].busy && flash[2'd3 - un].busy) un = 2'd3 - un;
      if (!flash[un].busy && $urandom_range(0, 1) == 0) un = 2'($urandom_range(0, 3));
      if (un == 2'd1 || un == 2'd2) begin
        wdly = flash[un].erase ? edly_r : pdly_r;
        if (flash[un].ph inside {P_RD_POLL, P_PG_POLL, P_ER_POLL})
          sb[0] = allow_err && ($urandom_range(0, 5) == 0);
        else if (flash[un].ph == P_WIP)
          sb[0] = (wdly <= 50) && ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) != 0) sb[6:5] = 2'b00;
      end
    end else begin
      op = snfcs_pkg::OpTick;
      un = 2'($urandom_range(0, 3));
    end
    send_request(op, un, ad, ln, sb);
  endtask

  always @(posedge clk_i) begin
    snfcs_pkg::res_t want;
    snfcs_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{unit: m_axis_tdata[1:0], kind: m_axis_tuser[0], opcode: m_axis_tdata[9:2],
              die: m_axis_tdata[10], info: m_axis_tdata[42:11],
              dlen: m_axis_tdata[69:43], code: m_axis_tdata[73:70], last: m_axis_tlast};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        fails++;
      end else begin
        want = expected_q.pop_front();
        if (got.unit !== want.unit || got.kind !== want.kind || got.opcode !== want.opcode ||
            got.die !== want.die || got.info !== want.info || got.dlen !== want.dlen ||
            got.code !== want.code || got.last !== want.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          fails++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  initial begin
    vec_t dir_tab [] = '{
      '{snfcs_pkg::OpRead, 2'd0, 32'h0, 27'd0, 8'h00, 1'b1, snfcs_pkg::RcBadUnit},
      '{snfcs_pkg::OpProgram, 2'd3, 32'hFFFF_FFFF, 27'h7FF_FFFF, 8'hFF, 1'b1,
        snfcs_pkg::RcBadUnit},
      '{snfcs_pkg::OpRead, 2'd1, 32'h0, 27'd67108865, 8'h00, 1'b1, snfcs_pkg::RcReadLong},
      '{snfcs_pkg::OpProgram, 2'd2, 32'h0, 27'd513, 8'h00, 1'b1, snfcs_pkg::RcWriteLong},
      '{snfcs_pkg::OpErase, 2'd1, 32'h0800_0000, 27'd0, 8'h00, 1'b1, snfcs_pkg::RcBadAddr},
      '{3'd5, 2'd1, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{3'd7, 2'd2, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h01, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpRead, 2'd1, 32'h03FF_FFFF, 27'd67108864, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpRead, 2'd2, 32'h0400_0000, 27'd1, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpErase, 2'd1, 32'h0, 27'd0, 8'h00, 1'b1, snfcs_pkg::RcBusy},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd2, 32'h0, 27'd0, 8'hFE, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd3, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd2, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpProgram, 2'd1, 32'h07FF_FFFF, 27'd512, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpErase, 2'd2, 32'h0400_1000, 27'h7FF_FFFF, 8'h00, 1'b0,
        snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd2, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd2, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd2, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h61, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd2, 32'h0, 27'd0, 8'h20, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd2, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpDone, 2'd1, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk},
      '{snfcs_pkg::OpTick, 2'd0, 32'h0, 27'd0, 8'h00, 1'b0, snfcs_pkg::RcOk}
    };
    for (int u = 0; u < 4; u++) flash[u] = '{ph: P_IDLE, default: '0};
    rto_r = 16'd1000;
    cto_r = 16'd1000;
    pdly_r = 20'd1;
    edly_r = 20'd20000;
    tries_r = 8'd25;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].op, dir_tab[i].un, dir_tab[i].ad, dir_tab[i].ln, dir_tab[i].sb);
      if (dir_tab[i].chk && expected_q[$].code !== dir_tab[i].code) begin
        $display("%0t: row %0d expected code %0d actual %0d", $time, i,
                 dir_tab[i].code, expected_q[$].code);
        fails++;
      end
    end
    drain();

    // The receiver holds off long enough for the result queue to fill.
    set_regs(16'hFFFF, 16'hFFFF, 20'd1, 20'd3, 8'd255);
    tx_idle = 27;
    rx_idle = 65;
    hold_cycles = 300;
    for (int i = 0; i < 20; i++) random_request(1'b0);
    drain();
    for (int i = 0; i < 20; i++) random_request(1'b0);
    drain();

    set_regs(16'd0, 16'd0, 20'd2, 20'd1, 8'd200);
    tx_idle = 65;
    rx_idle = 27;
    for (int i = 0; i < 50; i++) random_request(1'b0);
    drain();

    // Errors are sticky, so the run ends with the settings that provoke them.
    set_regs(16'd7, 16'd3, 20'hFFFFF, 20'd1, 8'd1);
    tx_idle = 0;
    rx_idle = 0;
    for (int i = 0; i < 34; i++) random_request(1'b1);
    drain();
    repeat (20) @(posedge clk_i);

    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end

endmodule
